/* hw/rtl/aepm_pkg.sv */
// Shared constants for the activity energy power monitor.
`default_nettype none

package aepm_pkg;

   localparam int COUNT_FIELD_W = 48;
   localparam int COEF_W        = 32;
   localparam int FREQ_W        = 12;
   localparam int POWER_W       = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_EXEC_ENERGY  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_STALL_ENERGY = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_L2_ENERGY    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_MEM_ENERGY   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_INTERVAL     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_FREQ         = 3'd5;

   localparam logic [COEF_W-1:0] EXEC_ENERGY_RST  = 32'd23791;
   localparam logic [COEF_W-1:0] STALL_ENERGY_RST = 32'd17961;
   localparam logic [COEF_W-1:0] L2_ENERGY_RST    = 32'd6693;
   localparam logic [COEF_W-1:0] MEM_ENERGY_RST   = 32'd3476357;
   localparam logic [COEF_W-1:0] INTERVAL_RST     = 32'd100000;
   localparam logic [FREQ_W-1:0] FREQ_RST         = 12'd256;

endpackage

`default_nettype wire

/* hw/rtl/aepm_smul.sv */
// Bit-serial shift-and-add multiply-accumulate unit, one multiplier bit per cycle.
`default_nettype none

module aepm_smul
   import aepm_pkg::*;
#(
   parameter int WIDTH = 64,
   parameter int MBITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] mcand,
   input  wire logic [MBITS-1:0] mplier,
   input  wire logic [WIDTH-1:0] acc_init,
   output logic                  done,
   output logic      [WIDTH-1:0] acc
);

   localparam int CNTW = $clog2(MBITS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic [WIDTH-1:0] mcand_ff, mcand_in;
   logic [MBITS-1:0] mplier_ff, mplier_in;
   logic [WIDTH-1:0] acc_ff, acc_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mcand_in  = mcand;
         mplier_in = mplier;
         acc_in    = acc_init;
      end else if (busy_ff) begin
         acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
         mcand_in  = {mcand_ff[WIDTH-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[MBITS-1:1]};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(MBITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

`default_nettype wire

/* hw/rtl/aepm_sdiv.sv */
// Bit-serial restoring divider with 32-bit saturated quotient.
`default_nettype none

module aepm_sdiv
   import aepm_pkg::*;
#(
   parameter int NUM_WIDTH = 76,
   parameter int DEN_WIDTH = 48
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [NUM_WIDTH-1:0] num,
   input  wire logic [DEN_WIDTH-1:0] den,
   output logic                      done,
   output logic      [POWER_W-1:0]   quot
);

   localparam int HW   = NUM_WIDTH - POWER_W;
   localparam int CMPW = (HW > DEN_WIDTH) ? HW : DEN_WIDTH;
   localparam int CNTW = $clog2(POWER_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [DEN_WIDTH-1:0] rem_ff, rem_in;
   logic [POWER_W-1:0]   low_ff, low_in;
   logic [POWER_W-1:0]   quot_ff, quot_in;
   logic [DEN_WIDTH:0]   trial;
   logic                 fits;
   logic                 sat;

   assign sat   = CMPW'(num[NUM_WIDTH-1:POWER_W]) >= CMPW'(den);
   assign trial = {rem_ff, low_ff[POWER_W-1]};
   assign fits  = trial >= {1'b0, den};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      if (start) begin
         cnt_in = '0;
         if (sat) begin
            quot_in = '1;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            rem_in  = DEN_WIDTH'(num[NUM_WIDTH-1:POWER_W]);
            low_in  = num[POWER_W-1:0];
            quot_in = '0;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? DEN_WIDTH'(trial - {1'b0, den}) : DEN_WIDTH'(trial);
         quot_in = {quot_ff[POWER_W-2:0], fits};
         low_in  = {low_ff[POWER_W-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(POWER_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

/* hw/rtl/activity_energy_power_monitor_unit.sv */
// Top level of the activity energy power monitor: sequencer, state and I/O registers.
//
// The req channel carries one snapshot of four cumulative activity counters per
// transaction. For each snapshot the block forms the counter changes, weights them
// with the per-event energies, adds them to the running energy total and returns
// exactly one rsp transaction: power in Q16.16 mW, a report flag and the cycle
// total before the snapshot. The csr port writes the six configuration registers
// at any clock edge with csr_wen high; unused indexes are ignored.
// The bit-serial multiply-accumulate unit sets most of the time from acceptance to
// rsp_tvalid (four passes over the energy weights); a snapshot that closes a report
// window adds a 12-step frequency scaling pass and a 32-step restoring division.
// A new snapshot is accepted only once the previous one is finished. The result sits
// in an output register, so a stalled receiver does not block acceptance of the next
// snapshot; the block then waits before overwriting the held result.
// Synchronous reset returns the state, lane and configuration registers to their
// defaults, clears the energy and cycle history and drops rsp_tvalid.
`default_nettype none

module activity_energy_power_monitor_unit
   import aepm_pkg::*;
#(
   parameter int COUNTER_WIDTH = 48,
   parameter int ENERGY_WIDTH  = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // exec_total, stall_total, l2_hit_total, mem_access_total (48 bits each)
   input  wire logic [4*COUNT_FIELD_W-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // power_mw (32 bits), window_start_cycle (48 bits)
   output logic [POWER_W+COUNT_FIELD_W-1:0] rsp_tdata,
   // reported
   output logic                         rsp_tuser,
   input  wire logic                    csr_wen,
   input  wire logic [CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CW   = COUNTER_WIDTH;
   localparam int EW   = ENERGY_WIDTH;
   localparam int NW   = ENERGY_WIDTH + FREQ_W;
   localparam int CMPW = (COUNTER_WIDTH > COEF_W) ? COUNTER_WIDTH : COEF_W;

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_MAC_LOAD   = 3'd1;
   localparam logic [2:0] ST_MAC_WAIT   = 3'd2;
   localparam logic [2:0] ST_UPDATE     = 3'd3;
   localparam logic [2:0] ST_CHECK      = 3'd4;
   localparam logic [2:0] ST_SCALE_WAIT = 3'd5;
   localparam logic [2:0] ST_DIV_WAIT   = 3'd6;
   localparam logic [2:0] ST_OUT        = 3'd7;

   logic [2:0]               state_ff, state_in;
   logic [1:0]               lane_ff, lane_in;
   logic [COEF_W-1:0]        coef_ff [4];
   logic [COEF_W-1:0]        interval_ff;
   logic [FREQ_W-1:0]        freq_ff;
   logic [CW-1:0]            in_ff [4];
   logic [CW-1:0]            last_ff [4];
   logic [CW-1:0]            cycle_total_ff;
   logic [CW-1:0]            report_cycle_ff;
   logic [CW-1:0]            start_ff;
   logic [CW-1:0]            span_ff;
   logic [EW-1:0]            energy_total_ff;
   logic [EW-1:0]            report_energy_ff;
   logic [POWER_W-1:0]       power_ff;
   logic                     rep_ff;
   logic                     rsp_valid_ff;
   logic [POWER_W-1:0]       rsp_power_ff;
   logic                     rsp_rep_ff;
   logic [COUNT_FIELD_W-1:0] rsp_start_ff;

   logic                     accept;
   logic                     out_load;
   logic                     fire;
   logic                     mac_start;
   logic                     mac_done;
   logic [EW-1:0]            mac_acc;
   logic [CW-1:0]            delta;
   logic [EW-1:0]            energy_delta;
   logic                     scale_start;
   logic                     scale_done;
   logic [NW-1:0]            scale_acc;
   logic                     div_done;
   logic [POWER_W-1:0]       div_quot;

   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign out_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
   assign fire         = CMPW'(span_ff) > CMPW'(interval_ff);
   assign mac_start    = (state_ff == ST_MAC_LOAD);
   assign delta        = in_ff[lane_ff] - last_ff[lane_ff];
   assign energy_delta = energy_total_ff - report_energy_ff;
   assign scale_start  = (state_ff == ST_CHECK) && fire;

   aepm_smul #(
      .WIDTH (EW),
      .MBITS (COEF_W)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .start    (mac_start),
      .mcand    (EW'(delta)),
      .mplier   (coef_ff[lane_ff]),
      .acc_init ((lane_ff == 2'd0) ? energy_total_ff : mac_acc),
      .done     (mac_done),
      .acc      (mac_acc)
   );

   aepm_smul #(
      .WIDTH (NW),
      .MBITS (FREQ_W)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .start    (scale_start),
      .mcand    (NW'(energy_delta)),
      .mplier   (freq_ff),
      .acc_init ('0),
      .done     (scale_done),
      .acc      (scale_acc)
   );

   aepm_sdiv #(
      .NUM_WIDTH (NW),
      .DEN_WIDTH (CW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start ((state_ff == ST_SCALE_WAIT) && scale_done),
      .num   (scale_acc),
      .den   (span_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      lane_in  = lane_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lane_in  = 2'd0;
               state_in = ST_MAC_LOAD;
            end
         end
         ST_MAC_LOAD: begin
            state_in = ST_MAC_WAIT;
         end
         ST_MAC_WAIT: begin
            if (mac_done) begin
               if (lane_ff == 2'd3) begin
                  state_in = ST_UPDATE;
               end else begin
                  lane_in  = lane_ff + 2'd1;
                  state_in = ST_MAC_LOAD;
               end
            end
         end
         ST_UPDATE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = fire ? ST_SCALE_WAIT : ST_OUT;
         end
         ST_SCALE_WAIT: begin
            if (scale_done) begin
               state_in = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         lane_ff          <= 2'd0;
         coef_ff[0]       <= EXEC_ENERGY_RST;
         coef_ff[1]       <= STALL_ENERGY_RST;
         coef_ff[2]       <= L2_ENERGY_RST;
         coef_ff[3]       <= MEM_ENERGY_RST;
         interval_ff      <= INTERVAL_RST;
         freq_ff          <= FREQ_RST;
         for (int i = 0; i < 4; i++) begin
            last_ff[i] <= '0;
         end
         cycle_total_ff   <= '0;
         report_cycle_ff  <= '0;
         energy_total_ff  <= '0;
         report_energy_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         lane_ff  <= lane_in;
         if (csr_wen) begin
            case (csr_addr)
               REG_EXEC_ENERGY:  coef_ff[0]  <= csr_wdata[COEF_W-1:0];
               REG_STALL_ENERGY: coef_ff[1]  <= csr_wdata[COEF_W-1:0];
               REG_L2_ENERGY:    coef_ff[2]  <= csr_wdata[COEF_W-1:0];
               REG_MEM_ENERGY:   coef_ff[3]  <= csr_wdata[COEF_W-1:0];
               REG_INTERVAL:     interval_ff <= csr_wdata[COEF_W-1:0];
               REG_FREQ:         freq_ff     <= csr_wdata[FREQ_W-1:0];
               default: begin
               end
            endcase
         end
         if (state_ff == ST_UPDATE) begin
            energy_total_ff <= mac_acc;
            cycle_total_ff  <= CW'(in_ff[0] + in_ff[1]);
            for (int i = 0; i < 4; i++) begin
               last_ff[i] <= in_ff[i];
            end
         end
         if (scale_start) begin
            report_cycle_ff  <= start_ff;
            report_energy_ff <= energy_total_ff;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         for (int i = 0; i < 4; i++) begin
            in_ff[i] <= CW'(req_tdata[i*COUNT_FIELD_W +: COUNT_FIELD_W]);
         end
      end
      if (state_ff == ST_UPDATE) begin
         start_ff <= cycle_total_ff;
         span_ff  <= cycle_total_ff - report_cycle_ff;
      end
      if (state_ff == ST_CHECK) begin
         rep_ff   <= fire;
         power_ff <= '0;
      end
      if ((state_ff == ST_DIV_WAIT) && div_done) begin
         power_ff <= div_quot;
      end
      if (out_load) begin
         rsp_power_ff <= power_ff;
         rsp_rep_ff   <= rep_ff;
         rsp_start_ff <= COUNT_FIELD_W'(start_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_start_ff, rsp_power_ff};
   assign rsp_tuser  = rsp_rep_ff;

   a_no_power_without_report: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[POWER_W-1:0] == '0))
      else $error("power reported without a closed window");

   a_one_at_a_time: assert property (
      @(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("new transaction accepted while a snapshot is in work");

   a_mac_done_in_wait: assert property (
      @(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == ST_MAC_WAIT))
      else $error("multiply-accumulate finished outside its wait state");

   a_div_done_in_wait: assert property (
      @(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("division finished outside its wait state");

endmodule

`default_nettype wire
